[rtl/core/serial_command_tokenizer_core_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the serial command tokenizer
// Clocked on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef SERIAL_COMMAND_TOKENIZER_CORE_ASSERT_SVH
`define SERIAL_COMMAND_TOKENIZER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

`define SCT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

`define SCT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SCT_ASSERT(label, prop, msg)
`define SCT_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

[rtl/core/sct_pkg.sv]
// ---------------------------------------------------------------------------
// sct_pkg
// Types and character codes shared by the serial command tokenizer.
// ---------------------------------------------------------------------------
package sct_pkg;

    typedef enum logic [1:0] {
        FIELD_CMD    = 2'd0,
        FIELD_FIRST  = 2'd1,
        FIELD_SECOND = 2'd2
    } field_t;

    typedef enum logic [1:0] {
        CONV_LEAD   = 2'd0,
        CONV_DIGITS = 2'd1,
        CONV_STOP   = 2'd2
    } conv_t;

    localparam logic [7:0] CHAR_TAB   = 8'd9;
    localparam logic [7:0] CHAR_FF    = 8'd12;
    localparam logic [7:0] CHAR_CR    = 8'd13;
    localparam logic [7:0] CHAR_SPACE = 8'd32;
    localparam logic [7:0] CHAR_BANG  = 8'd33;
    localparam logic [7:0] CHAR_PLUS  = 8'd43;
    localparam logic [7:0] CHAR_MINUS = 8'd45;
    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_NINE  = 8'd57;

endpackage

[rtl/core/sct_byte_if.sv]
// ---------------------------------------------------------------------------
// sct_byte_if
// Valid/ready channel carrying one received byte per request.
// ---------------------------------------------------------------------------
interface sct_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;

    modport source (output valid, output char_in, input ready);
    modport sink (input valid, input char_in, output ready);
endinterface

[rtl/core/sct_token_if.sv]
// ---------------------------------------------------------------------------
// sct_token_if
// Valid/ready channel carrying one tokenized command line per request.
// ---------------------------------------------------------------------------
interface sct_token_if;
    logic               valid;
    logic               ready;
    logic        [7:0]  command_code;
    logic signed [31:0] first_value;
    logic signed [31:0] second_value;
    logic        [1:0]  fields_seen;

    modport source (
        output valid, output command_code, output first_value,
        output second_value, output fields_seen, input ready
    );
    modport sink (
        input valid, input command_code, input first_value,
        input second_value, input fields_seen, output ready
    );
endinterface

[rtl/core/sct_in_stage.sv]
// ---------------------------------------------------------------------------
// sct_in_stage
// Input register for received bytes.
// ---------------------------------------------------------------------------
module sct_in_stage (
    input  logic         clk,
    input  logic         rst_n,
    sct_byte_if.sink     up,
    sct_byte_if.source   down
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] char_reg;

    assign up.ready     = !valid_reg || down.ready;
    assign valid_next   = up.ready ? up.valid : valid_reg;
    assign down.valid   = valid_reg;
    assign down.char_in = char_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up.valid && up.ready)
        begin
            char_reg <= up.char_in;
        end
    end

endmodule

[rtl/core/sct_engine.sv]
// ---------------------------------------------------------------------------
// sct_engine
// Field tracking and running atoi conversion; emits a line on terminator.
// ---------------------------------------------------------------------------
`include "serial_command_tokenizer_core_assert.svh"

module sct_engine (
    input  logic         clk,
    input  logic         rst_n,
    sct_byte_if.sink     chars,
    sct_token_if.source  line
);

    import sct_pkg::*;

    field_t      phase_reg,  phase_next;
    conv_t       stage_reg,  stage_next;
    logic [7:0]  code_reg,   code_next;
    logic [31:0] saved_reg,  saved_next;
    logic [31:0] accum_reg,  accum_next;
    logic        neg_reg,    neg_next;

    logic [7:0]  ch;
    logic        is_term;
    logic        is_space;
    logic        is_digit;
    logic        is_skip;
    logic        is_sign;
    logic        take;
    logic [31:0] finish;
    logic [31:0] mul10;

    assign ch       = chars.char_in;
    assign is_term  = (ch == CHAR_CR) || (ch == CHAR_BANG);
    assign is_space = (ch == CHAR_SPACE);
    assign is_digit = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
    assign is_skip  = (ch >= CHAR_TAB) && (ch <= CHAR_FF);
    assign is_sign  = (ch == CHAR_PLUS) || (ch == CHAR_MINUS);

    assign chars.ready = !is_term || line.ready;
    assign take        = chars.valid && chars.ready;

    assign finish = neg_reg ? (32'd0 - accum_reg) : accum_reg;
    assign mul10  = {accum_reg[28:0], 3'b000} + {accum_reg[30:0], 1'b0}
                  + {28'd0, 4'(ch - CHAR_ZERO)};

    assign line.valid        = chars.valid && is_term;
    assign line.command_code = code_reg;
    assign line.fields_seen  = phase_reg;

    always_comb
    begin
        unique case (phase_reg)
            FIELD_CMD:
            begin
                line.first_value  = '0;
                line.second_value = '0;
            end
            FIELD_FIRST:
            begin
                line.first_value  = finish;
                line.second_value = '0;
            end
            default:
            begin
                line.first_value  = saved_reg;
                line.second_value = finish;
            end
        endcase
    end

    always_comb
    begin
        phase_next = phase_reg;
        stage_next = stage_reg;
        code_next  = code_reg;
        saved_next = saved_reg;
        accum_next = accum_reg;
        neg_next   = neg_reg;

        if (take)
        begin
            priority if (is_term)
            begin
                phase_next = FIELD_CMD;
                stage_next = CONV_LEAD;
                code_next  = '0;
                saved_next = '0;
                accum_next = '0;
                neg_next   = 1'b0;
            end
            else if (is_space)
            begin
                if (phase_reg == FIELD_CMD)
                begin
                    phase_next = FIELD_FIRST;
                end
                else if (phase_reg == FIELD_FIRST)
                begin
                    phase_next = FIELD_SECOND;
                    saved_next = finish;
                    stage_next = CONV_LEAD;
                    accum_next = '0;
                    neg_next   = 1'b0;
                end
            end
            else if (phase_reg == FIELD_CMD)
            begin
                code_next = ch;
            end
            else
            begin
                unique case (stage_reg)
                    CONV_LEAD:
                    begin
                        priority if (is_skip)
                        begin
                            stage_next = CONV_LEAD;
                        end
                        else if (is_sign)
                        begin
                            neg_next   = (ch == CHAR_MINUS);
                            stage_next = CONV_DIGITS;
                        end
                        else if (is_digit)
                        begin
                            accum_next = mul10;
                            stage_next = CONV_DIGITS;
                        end
                        else
                        begin
                            stage_next = CONV_STOP;
                        end
                    end
                    CONV_DIGITS:
                    begin
                        if (is_digit)
                        begin
                            accum_next = mul10;
                        end
                        else
                        begin
                            stage_next = CONV_STOP;
                        end
                    end
                    default:
                    begin
                        stage_next = CONV_STOP;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= FIELD_CMD;
            stage_reg <= CONV_LEAD;
            code_reg  <= '0;
            saved_reg <= '0;
            accum_reg <= '0;
            neg_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            stage_reg <= stage_next;
            code_reg  <= code_next;
            saved_reg <= saved_next;
            accum_reg <= accum_next;
            neg_reg   <= neg_next;
        end
    end

    // a terminator leaves the tokenizer fully cleared
    `SCT_ASSERT_NEXT(a_term_clears, take && is_term, phase_reg == FIELD_CMD && code_reg == 8'd0 && accum_reg == 32'd0 && saved_reg == 32'd0, "state not cleared after terminator")
    // no conversion activity before the first space
    `SCT_ASSERT(a_cmd_no_accum, phase_reg != FIELD_CMD || (accum_reg == 32'd0 && stage_reg == CONV_LEAD && !neg_reg), "argument state active in command field")

endmodule

[rtl/core/sct_out_stage.sv]
// ---------------------------------------------------------------------------
// sct_out_stage
// Result register for tokenized lines.
// ---------------------------------------------------------------------------
`include "serial_command_tokenizer_core_assert.svh"

module sct_out_stage (
    input  logic         clk,
    input  logic         rst_n,
    sct_token_if.sink    up,
    sct_token_if.source  down
);

    logic               valid_reg;
    logic               valid_next;
    logic        [7:0]  code_reg;
    logic signed [31:0] first_reg;
    logic signed [31:0] second_reg;
    logic        [1:0]  fields_reg;

    assign up.ready          = !valid_reg || down.ready;
    assign valid_next        = up.ready ? up.valid : valid_reg;
    assign down.valid        = valid_reg;
    assign down.command_code = code_reg;
    assign down.first_value  = first_reg;
    assign down.second_value = second_reg;
    assign down.fields_seen  = fields_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up.valid && up.ready)
        begin
            code_reg   <= up.command_code;
            first_reg  <= up.first_value;
            second_reg <= up.second_value;
            fields_reg <= up.fields_seen;
        end
    end

    // a loaded line is presented on the next cycle
    `SCT_ASSERT_NEXT(a_load_shows, up.valid && up.ready, valid_reg, "loaded result not presented")

endmodule

[rtl/core/serial_command_tokenizer_core.sv]
// ---------------------------------------------------------------------------
// serial_command_tokenizer_core
// Splits a serial command line into a code and two atoi-converted values.
// ---------------------------------------------------------------------------
// Usage:
//   chars  : one received byte per request (valid/ready).
//   tokens : one request per line terminator (CR or '!'), carrying the
//            command code, both argument values and the field reached.
//   Bytes are taken at one per cycle while no terminator is held up. A
//   byte passes an input register and is then folded into the line state;
//   a terminator's line is loaded into the result register and presented
//   on tokens from there.
//   Throughput is one byte per cycle while tokens does not stall; the
//   multiply by ten and add in the conversion logic are combinational.
//   When tokens stalls, the result register holds its line; bytes other
//   than terminators keep flowing, and a second terminator waits in the
//   input register until the held line is taken.
//   Reset clears the input and result registers' valid flags and the
//   line state (field, code, saved value, accumulator, sign, stage).
// ---------------------------------------------------------------------------
module serial_command_tokenizer_core (
    input  logic         clk,
    input  logic         rst_n,
    sct_byte_if.sink     chars,
    sct_token_if.source  tokens
);

    sct_byte_if  byte_q ();
    sct_token_if line_q ();

    sct_in_stage u_in_stage (
        .clk   (clk),
        .rst_n (rst_n),
        .up    (chars),
        .down  (byte_q)
    );

    sct_engine u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .chars (byte_q),
        .line  (line_q)
    );

    sct_out_stage u_out_stage (
        .clk   (clk),
        .rst_n (rst_n),
        .up    (line_q),
        .down  (tokens)
    );

endmodule
